// File: design/ffba_pkg.sv
// ffba_pkg: shared types and codes for the first-fit block allocator
// holds item structs, command/status codes and controller/datapath links
// no dependencies
`default_nettype none

package ffba_pkg;

	// default sizes
	localparam int MEM_CELLS_DEF   = 128;
	localparam int HANDLE_BITS_DEF = 16;

	// pool size register reset value
	localparam logic [7:0] POOL_RESET = 8'd128;

	// command codes
	localparam logic [1:0] CMD_ALLOC  = 2'd0;
	localparam logic [1:0] CMD_ERASE  = 2'd1;
	localparam logic [1:0] CMD_DEFRAG = 2'd2;

	// result status codes
	localparam logic [1:0] ST_ALLOCATED     = 2'd0;
	localparam logic [1:0] ST_NO_SPACE      = 2'd1;
	localparam logic [1:0] ST_ILLEGAL_ERASE = 2'd2;

	// request item
	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  alloc_size;
		logic [15:0] erase_handle;
	} ffba_in_t;

	// result item
	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] handle;
	} ffba_out_t;

	// controller to datapath commands
	typedef struct packed {
		logic       clear_step;
		logic       start;
		logic       scan;
		logic       fill_step;
		logic       zero_step;
		logic       post;
		logic [1:0] post_status;
	} ffba_ctl_t;

	// datapath to controller status
	typedef struct packed {
		logic [1:0] cmd;
		logic       alloc_bad;
		logic       hit;
		logic       scan_done;
		logic       found;
		logic       fill_last;
		logic       zero_done;
		logic       clear_last;
		logic       out_free;
	} ffba_sts_t;

endpackage

`default_nettype wire

// File: design/ffba_ctrl.sv
// ffba_ctrl: sequencer for clear, scan, fill, zero and result posting
// depends on ffba_pkg for command/status structs and codes
`default_nettype none

module ffba_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  req_valid,
	output logic                 req_stall,
	input  ffba_pkg::ffba_sts_t  sts,
	output ffba_pkg::ffba_ctl_t  ctl
);
	import ffba_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_FILL,
		S_ZERO,
		S_POST
	} state_t;

	state_t     state_q;
	state_t     state_d;
	logic [1:0] post_q;
	logic [1:0] post_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		post_d  = post_q;
		ctl     = '0;
		ctl.post_status = post_q;
		unique case (state_q)
			S_CLEAR: begin
				ctl.clear_step = 1'b1;
				if (sts.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					ctl.start = 1'b1;
					state_d   = S_SCAN;
				end
			end
			S_SCAN: begin
				ctl.scan = 1'b1;
				unique case (sts.cmd)
					CMD_ALLOC: begin
						priority if (sts.alloc_bad) begin
							post_d  = ST_NO_SPACE;
							state_d = S_POST;
						end else if (sts.hit) begin
							state_d = S_FILL;
						end else if (sts.scan_done) begin
							post_d  = ST_NO_SPACE;
							state_d = S_POST;
						end
					end
					CMD_ERASE: begin
						if (sts.scan_done) begin
							post_d  = ST_ILLEGAL_ERASE;
							state_d = sts.found ? S_IDLE : S_POST;
						end
					end
					CMD_DEFRAG: begin
						if (sts.scan_done) begin
							state_d = S_ZERO;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_FILL: begin
				ctl.fill_step = 1'b1;
				if (sts.fill_last) begin
					post_d  = ST_ALLOCATED;
					state_d = S_POST;
				end
			end
			S_ZERO: begin
				if (sts.zero_done) begin
					state_d = S_IDLE;
				end else begin
					ctl.zero_step = 1'b1;
				end
			end
			S_POST: begin
				if (sts.out_free) begin
					ctl.post = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			post_q  <= ST_NO_SPACE;
		end else begin
			state_q <= state_d;
			post_q  <= post_d;
		end
	end

	// new item taken only between commands
	assign req_stall = (state_q != S_IDLE);

`ifndef SYNTHESIS
	// a result is never posted over one still waiting
	a_post_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.post |-> sts.out_free)
		else $error("result posted while output register busy");

	// a new item is only started from idle, and start always leads into scan
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |=> (state_q == S_SCAN))
		else $error("start did not enter scan");

	// fill is only entered on an alloc hit
	a_fill_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && state_d == S_FILL) |-> (sts.hit && !sts.alloc_bad))
		else $error("fill entered without a free run");
`endif

endmodule

`default_nettype wire

// File: design/ffba_datapath.sv
// ffba_datapath: cell owner memory, scan pointers, handle counter, result register
// depends on ffba_pkg for item structs, command/status structs and codes
`default_nettype none

module ffba_datapath #(
	parameter int MEM_CELLS   = ffba_pkg::MEM_CELLS_DEF,
	parameter int HANDLE_BITS = ffba_pkg::HANDLE_BITS_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_we,
	input  wire  [7:0]           cfg_wdata,
	input  ffba_pkg::ffba_in_t   req_item,
	input  ffba_pkg::ffba_ctl_t  ctl,
	output ffba_pkg::ffba_sts_t  sts,
	input  wire                  rsp_stall,
	output logic                 rsp_valid,
	output ffba_pkg::ffba_out_t  rsp_item
);
	import ffba_pkg::*;

	localparam int CNT_W = $clog2(MEM_CELLS + 1);
	localparam int CW    = (CNT_W > 8) ? CNT_W : 8;
	localparam int AW    = (MEM_CELLS > 1) ? $clog2(MEM_CELLS) : 1;
	localparam int CMP_W = (HANDLE_BITS > 16) ? HANDLE_BITS : 16;

	localparam logic [CW-1:0]          MEM_LIM  = CW'(MEM_CELLS);
	localparam logic [CW-1:0]          LAST_IDX = CW'(MEM_CELLS - 1);
	localparam logic [HANDLE_BITS-1:0] HMAX     = {HANDLE_BITS{1'b1}};

	// cell owner memory
	logic [HANDLE_BITS-1:0] mem [MEM_CELLS];

	logic [7:0]             pool_q;
	logic [HANDLE_BITS-1:0] next_handle_q;
	logic [1:0]             cmd_q;
	logic [7:0]             size_q;
	logic [15:0]            ehandle_q;
	logic [CW-1:0]          rd_addr_q;
	logic [CW-1:0]          wptr_q;
	logic [CW-1:0]          run_q;
	logic [CW-1:0]          fill_end_q;
	logic                   found_q;
	logic                   eval_s1;
	logic [CW-1:0]          idx_s1;
	logic [HANDLE_BITS-1:0] rdata_s1;
	logic                   out_valid_q;
	ffba_out_t              out_item_q;

	logic [CW-1:0]          pool_ext;
	logic [CW-1:0]          cells;
	logic [CW-1:0]          size_ext;
	logic [CW-1:0]          run_inc;
	logic [CW-1:0]          fill_start;
	logic                   rd_issue;
	logic                   data_free;
	logic                   hit;
	logic                   erase_hit;
	logic                   pack;
	logic                   we;
	logic [CW-1:0]          waddr;
	logic [HANDLE_BITS-1:0] wdata;
	logic                   out_free;
	logic [CMP_W-1:0]       hx;

	// pool bound and scan decisions
	always_comb begin
		pool_ext   = CW'(pool_q);
		cells      = (pool_ext > MEM_LIM) ? MEM_LIM : pool_ext;
		size_ext   = CW'(size_q);
		run_inc    = run_q + CW'(1);
		fill_start = idx_s1 + CW'(1) - size_ext;
		rd_issue   = ctl.scan && (rd_addr_q < cells);
		data_free  = (rdata_s1 == '0);
		hit        = ctl.scan && eval_s1 && (cmd_q == CMD_ALLOC) && data_free
			&& (run_inc == size_ext);
		erase_hit  = eval_s1 && (cmd_q == CMD_ERASE) && !data_free
			&& (CMP_W'(rdata_s1) == CMP_W'(ehandle_q));
		pack       = eval_s1 && (cmd_q == CMD_DEFRAG) && !data_free;
		hx         = CMP_W'(next_handle_q);
		out_free   = !out_valid_q || !rsp_stall;
	end

	// memory write port select
	always_comb begin
		we    = 1'b0;
		waddr = wptr_q;
		wdata = '0;
		priority if (ctl.clear_step || ctl.zero_step) begin
			we = 1'b1;
		end else if (ctl.fill_step) begin
			we    = 1'b1;
			wdata = next_handle_q;
		end else if (erase_hit) begin
			we    = 1'b1;
			waddr = idx_s1;
		end else if (pack) begin
			we    = 1'b1;
			wdata = rdata_s1;
		end
	end

	// memory ports
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr[AW-1:0]] <= wdata;
		end
		if (rd_issue) begin
			rdata_s1 <= mem[rd_addr_q[AW-1:0]];
		end
	end

	// item latch and scan stage payload
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			cmd_q     <= req_item.cmd;
			size_q    <= req_item.alloc_size;
			ehandle_q <= req_item.erase_handle;
		end
		idx_s1 <= rd_addr_q;
		if (hit) begin
			fill_end_q <= idx_s1;
		end
	end

	// config, handle counter and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q        <= POOL_RESET;
			next_handle_q <= HANDLE_BITS'(1);
			rd_addr_q     <= '0;
			wptr_q        <= '0;
			run_q         <= '0;
			found_q       <= 1'b0;
			eval_s1       <= 1'b0;
		end else begin
			if (cfg_we) begin
				pool_q <= cfg_wdata;
			end
			if (ctl.post && (ctl.post_status == ST_ALLOCATED)) begin
				next_handle_q <= (next_handle_q >= HMAX) ? HANDLE_BITS'(1)
					: next_handle_q + HANDLE_BITS'(1);
			end
			eval_s1 <= rd_issue;
			if (ctl.start) begin
				rd_addr_q <= '0;
				wptr_q    <= '0;
				run_q     <= '0;
				found_q   <= 1'b0;
			end else begin
				if (rd_issue) begin
					rd_addr_q <= rd_addr_q + CW'(1);
				end
				if (eval_s1) begin
					run_q <= data_free ? run_inc : '0;
				end
				if (erase_hit) begin
					found_q <= 1'b1;
				end
				if (hit) begin
					wptr_q <= fill_start;
				end else if (ctl.clear_step || ctl.fill_step || ctl.zero_step || pack) begin
					wptr_q <= wptr_q + CW'(1);
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.post) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.post) begin
			out_item_q.status <= ctl.post_status;
			out_item_q.handle <= (ctl.post_status == ST_ALLOCATED) ? hx[15:0] : 16'd0;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_item  = out_item_q;

	// status to controller
	always_comb begin
		sts            = '0;
		sts.cmd        = cmd_q;
		sts.alloc_bad  = (size_q == 8'd0) || (size_ext > cells);
		sts.hit        = hit;
		sts.scan_done  = (rd_addr_q >= cells) && !eval_s1;
		sts.found      = found_q;
		sts.fill_last  = (wptr_q == fill_end_q);
		sts.zero_done  = (wptr_q >= cells);
		sts.clear_last = (wptr_q == LAST_IDX);
		sts.out_free   = out_free;
	end

`ifndef SYNTHESIS
	// every memory write lands inside the array
	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (waddr < MEM_LIM))
		else $error("memory write outside the cell array");

	// reads stay inside the configured pool
	a_rd_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_issue |-> (rd_addr_q < cells))
		else $error("scan read beyond the pool");

	// handle zero is never issued
	a_handle_nz: assert property (@(posedge clk) disable iff (!arst_n)
		next_handle_q != '0)
		else $error("handle counter reached zero");

	// fill never runs past the end of the found run
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fill_step |-> (wptr_q <= fill_end_q))
		else $error("fill pointer past end of run");
`endif

endmodule

`default_nettype wire

// File: design/first_fit_block_allocator_unit.sv
// first_fit_block_allocator_unit: top level of the first-fit block allocator
// instantiates ffba_ctrl and ffba_datapath, types from ffba_pkg
//
// Usage: a request item (cmd, alloc_size, erase_handle) is taken when req_valid
// is high and req_stall is low. Alloc always returns one result item (status,
// handle); erase returns one only when no cell held the handle; defragment and
// the unused command return none. Results leave on rsp_valid/rsp_stall from an
// output register, so a waiting result does not block the next request.
// With P = min(pool_size, MEM_CELLS): every command scans the pool at one cell
// per cycle through the single read port. Alloc adds one write per requested
// cell; defragment adds one write per free cell after packing, up to P more.
// The pool_size register must be written through cfg_we/cfg_wdata only while
// idle; the block itself does not enforce this.
// Reset: arst_n clears control state, sets pool_size to 128 and the handle
// counter to 1, then a clearing pass over all MEM_CELLS cells zeroes the cell
// memory with req_stall held high. A stalled result holds until taken; a
// result that must post while the output register is full waits for it.
`default_nettype none

module first_fit_block_allocator_unit #(
	parameter int MEM_CELLS   = ffba_pkg::MEM_CELLS_DEF,
	parameter int HANDLE_BITS = ffba_pkg::HANDLE_BITS_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_we,
	input  wire  [7:0]          cfg_wdata,
	input  wire                 req_valid,
	output logic                req_stall,
	input  ffba_pkg::ffba_in_t  req_item,
	output logic                rsp_valid,
	input  wire                 rsp_stall,
	output ffba_pkg::ffba_out_t rsp_item
);
	import ffba_pkg::*;

	ffba_ctl_t ctl;
	ffba_sts_t sts;

	// sequencer
	ffba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	// memory and result datapath
	ffba_datapath #(
		.MEM_CELLS   (MEM_CELLS),
		.HANDLE_BITS (HANDLE_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_item  (req_item),
		.ctl       (ctl),
		.sts       (sts),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp_item  (rsp_item)
	);

endmodule

`default_nettype wire

// File: bench/testbench.sv
// testbench: self-checking bench for first_fit_block_allocator_unit
// predicts each result from its own copy of the pool and the handle counter
// depends on ffba_pkg and the allocator RTL only

module testbench;
	import ffba_pkg::*;

	localparam int          MEM_CELLS      = MEM_CELLS_DEF;
	localparam logic [15:0] HANDLE_MAX     = 16'hFFFF;
	localparam logic [1:0]  CMD_UNUSED     = 2'd3;
	localparam int          RANDOM_ITEMS   = 1300;
	localparam int          RANDOM_PHASES  = 11;
	localparam int          STEADY_ITEMS   = 40;
	localparam int          SETTLE_CYCLES  = 2 * MEM_CELLS + 8;
	localparam int          WATCHDOG_LIMIT = 4000;

	logic      clk;
	logic      arst_n    = 1'b0;
	logic      cfg_we    = 1'b0;
	logic [7:0] cfg_wdata = 8'd0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	ffba_in_t  req_item  = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	ffba_out_t rsp_item;

	// allocator state as the bench sees it
	logic [15:0] pool_owner [MEM_CELLS];
	logic [15:0] issue_handle;
	logic [7:0]  pool_cfg;
	logic [15:0] granted_handle;

	ffba_out_t   expected_results [$];
	ffba_out_t   oldest_expected;
	int          fail_count  = 0;
	int          stall_burst = 0;
	bit          idling      = 1'b0;

	first_fit_block_allocator_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// cells in play, a pool size above the memory acts as the memory
	function automatic int active_cells();
		return (pool_cfg > MEM_CELLS) ? MEM_CELLS : int'(pool_cfg);
	endfunction

	function automatic ffba_in_t make_request(input logic [1:0] cmd, input logic [7:0] size,
		input logic [15:0] handle);
		ffba_in_t item;
		item.cmd          = cmd;
		item.alloc_size   = size;
		item.erase_handle = handle;
		return item;
	endfunction

	// owner of some used cell in the pool, 0 when the pool is empty
	function automatic logic [15:0] held_handle();
		int cells, start, k, idx;
		logic [15:0] found;
		cells = active_cells();
		found = '0;
		if (cells > 0) begin
			start = $urandom_range(0, cells - 1);
			for (k = 0; k < cells && found == 0; k++) begin
				idx = (start + k) % cells;
				found = pool_owner[idx];
			end
		end
		return found;
	endfunction

	// update the pool for one accepted item and queue its result, if any
	task automatic apply_request(input ffba_in_t item);
		int cells, run, fill_at, w, i;
		bit freed;
		ffba_out_t res;
		cells = active_cells();
		granted_handle = '0;
		res.handle = '0;
		case (item.cmd)
			CMD_ALLOC: begin
				res.status = ST_NO_SPACE;
				run = 0;
				fill_at = -1;
				if (item.alloc_size != 0 && item.alloc_size <= cells) begin
					for (i = 0; i < cells && fill_at < 0; i++) begin
						run = (pool_owner[i] == 0) ? run + 1 : 0;
						if (run == item.alloc_size)
							fill_at = i + 1 - run;
					end
				end
				if (fill_at >= 0) begin
					for (i = fill_at; i < fill_at + int'(item.alloc_size); i++)
						pool_owner[i] = issue_handle;
					res.status = ST_ALLOCATED;
					res.handle = issue_handle;
					granted_handle = issue_handle;
					issue_handle = (issue_handle == HANDLE_MAX) ? 16'd1 : issue_handle + 16'd1;
				end
				expected_results.push_back(res);
			end
			CMD_ERASE: begin
				freed = 1'b0;
				for (i = 0; i < cells; i++) begin
					if (pool_owner[i] != 0 && pool_owner[i] == item.erase_handle) begin
						pool_owner[i] = '0;
						freed = 1'b1;
					end
				end
				if (!freed) begin
					res.status = ST_ILLEGAL_ERASE;
					expected_results.push_back(res);
				end
			end
			CMD_DEFRAG: begin
				w = 0;
				for (i = 0; i < cells; i++) begin
					if (pool_owner[i] != 0) begin
						pool_owner[w] = pool_owner[i];
						w++;
					end
				end
				while (w < cells) begin
					pool_owner[w] = '0;
					w++;
				end
			end
			default: ;
		endcase
	endtask

	// present one item, hold it until taken, then predict
	task automatic send_request(input ffba_in_t item);
		if (idling && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_item  <= item;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		apply_request(item);
	endtask

	task automatic alloc_cells(input logic [7:0] size, output logic [15:0] given);
		send_request(make_request(CMD_ALLOC, size, 16'($urandom)));
		given = granted_handle;
	endtask

	task automatic erase_block(input logic [15:0] handle);
		send_request(make_request(CMD_ERASE, 8'($urandom), handle));
	endtask

	task automatic pack_pool();
		send_request(make_request(CMD_DEFRAG, 8'($urandom), 16'($urandom)));
	endtask

	// stop sending until every queued result has come back
	task automatic wait_results_drained();
		req_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	// pool size write while the block is idle; items with no result may still run
	task automatic set_pool_size(input logic [7:0] value);
		wait_results_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		pool_cfg  = value;
	endtask

	// field extremes, every command and the corner cases at the reset pool size
	task automatic test_alloc_erase_defrag();
		logic [15:0] whole, pair, triple, single;
		alloc_cells(8'd0, whole);
		alloc_cells(8'd255, whole);
		alloc_cells(8'd128, whole);
		alloc_cells(8'd1, single);
		erase_block(whole);
		alloc_cells(8'd2, pair);
		alloc_cells(8'd3, triple);
		alloc_cells(8'd1, single);
		// hole in the middle, then close it up
		erase_block(triple);
		pack_pool();
		erase_block(16'd0);
		erase_block(16'hFFFF);
		erase_block(triple);
		send_request(make_request(CMD_UNUSED, 8'hFF, 16'hFFFF));
	endtask

	// empty pool, oversized pool and cells left above a lowered pool size
	task automatic test_pool_size_limits();
		logic [15:0] upper, lower;
		set_pool_size(8'd0);
		alloc_cells(8'd1, lower);
		erase_block(issue_handle - 16'd1);
		set_pool_size(8'd255);
		alloc_cells(8'd125, upper);
		set_pool_size(8'd100);
		erase_block(upper);
		alloc_cells(8'd97, lower);
		pack_pool();
		// the cells above 100 must still hold the old block
		set_pool_size(8'd128);
		erase_block(upper);
		erase_block(lower);
	endtask

	// mostly sensible traffic with some noise, over a range of pool sizes
	task automatic test_random_traffic();
		int phase, n, cells, pick;
		logic [7:0] value;
		logic [15:0] held, dummy;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0:       value = 8'd128;
				1:       value = 8'd1;
				2:       value = 8'd2;
				3:       value = 8'd37;
				4:       value = 8'd255;
				5:       value = 8'd0;
				6:       value = 8'd128;
				7:       value = 8'd5;
				8:       value = 8'd64;
				9:       value = 8'd16;
				default: value = 8'd128;
			endcase
			set_pool_size(value);
			idling = ($urandom_range(0, 3) != 0);
			for (n = 0; n < RANDOM_ITEMS / RANDOM_PHASES; n++) begin
				if (phase == 3 && n == 60)
					wait_results_drained();
				cells = active_cells();
				pick  = $urandom_range(0, 99);
				held  = held_handle();
				if (pick < 30 && held != 0)
					erase_block(held);
				else if (pick < 38)
					pack_pool();
				else if (pick < 46)
					alloc_cells(8'($urandom_range(0, 255)), dummy);
				else if (pick < 52)
					erase_block(16'($urandom_range(0, 16'hFFFF)));
				else if (pick < 56)
					send_request(make_request(CMD_UNUSED, 8'($urandom), 16'($urandom)));
				else if (cells == 0)
					alloc_cells(8'd1, dummy);
				else if ($urandom_range(0, 9) == 0)
					alloc_cells(8'($urandom_range(1, cells)), dummy);
				else
					alloc_cells(8'($urandom_range(1, (cells + 3) / 4)), dummy);
			end
		end
	endtask

	// last stretch with no idling on either side, items back to back
	task automatic test_back_to_back();
		logic [15:0] h;
		int n;
		idling = 1'b0;
		set_pool_size(8'd128);
		for (n = 0; n < STEADY_ITEMS; n++) begin
			h = held_handle();
			if (n % 3 == 2 && h != 0)
				erase_block(h);
			else if (n % 7 == 6)
				pack_pool();
			else
				alloc_cells(8'($urandom_range(1, 16)), h);
		end
	endtask

	// random result stall in bursts, only while idling is set
	always @(posedge clk) begin
		if (stall_burst > 0)
			stall_burst--;
		else if (idling && $urandom_range(0, 5) == 0) begin
			rsp_stall   <= 1'b1;
			stall_burst = $urandom_range(0, 2);
		end else
			rsp_stall <= 1'b0;
	end

	// compare each result item with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got status %0d handle %0d",
					$time, rsp_item.status, rsp_item.handle);
				fail_count++;
			end else begin
				oldest_expected = expected_results.pop_front();
				if (rsp_item.status !== oldest_expected.status) begin
					$display("%0t: status mismatch, expected %0d, got %0d",
						$time, oldest_expected.status, rsp_item.status);
					fail_count++;
				end
				if (rsp_item.handle !== oldest_expected.handle) begin
					$display("%0t: handle mismatch, expected %0d, got %0d",
						$time, oldest_expected.handle, rsp_item.handle);
					fail_count++;
				end
			end
		end
	end

	// give up when nothing moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_we)
				quiet = 0;
			else
				quiet++;
		end
		$display("** first_fit_block_allocator_unit: FAILED **");
		$finish;
	end

	// test sequence
	initial begin
		foreach (pool_owner[i])
			pool_owner[i] = '0;
		issue_handle = 16'd1;
		pool_cfg     = POOL_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_alloc_erase_defrag();
		test_pool_size_limits();
		test_random_traffic();
		test_back_to_back();

		wait_results_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("** first_fit_block_allocator_unit: PASSED **");
		else
			$display("** first_fit_block_allocator_unit: FAILED **");
		$finish;
	end

endmodule
